@@ hdl/sxfr_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the frame receiver
package sxfr_pkg;

    // frame geometry
    localparam int PAYLOAD_BYTES = 16;
    localparam int IDX_W         = 6;
    localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'd1;
    localparam logic [7:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RST = 8'hCC;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_first;
        logic       start_data;
        logic       store_byte;
        logic       emit_event;
        logic [1:0] event_status;
        logic       rep_start;
        logic       rd_issue;
        logic       emit_data;
    } sxfr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic first_hit;
        logic second_hit;
        logic count_zero;
        logic sum_ok;
        logic slot_free;
        logic rep_last;
    } sxfr_sts_t;

endpackage

@@ hdl/sxfr_ctrl.sv @@
// controller: frame sync state machine, pending flag and replay sequencing
module sxfr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic                 line_error,
    input  sxfr_pkg::sxfr_sts_t  sts,
    output sxfr_pkg::sxfr_cmd_t  cmd
);

    // state codes
    localparam logic [2:0] ST_HUNT1 = 3'd0;
    localparam logic [2:0] ST_HUNT2 = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       frame_pending_reg;
    logic       frame_pending_next;
    logic       parsing;
    logic       accept;
    logic       byte_in;
    logic       consume;

    // input handshake: the checksum word needs a free output slot
    assign parsing  = (state_reg == ST_HUNT1) || (state_reg == ST_HUNT2) ||
                      (state_reg == ST_DATA);
    assign in_ready = parsing &&
                      (!((state_reg == ST_DATA) && sts.count_zero) || sts.slot_free);
    assign accept   = in_valid && in_ready;
    assign byte_in  = accept && !func && !line_error;
    assign consume  = accept && func;

    // next state and commands
    always_comb
    begin
        state_next         = state_reg;
        frame_pending_next = frame_pending_reg;
        cmd                = '0;
        cmd.event_status   = sxfr_pkg::STATUS_OK;
        if (consume)
        begin
            frame_pending_next = 1'b0;
        end
        case (state_reg)
            ST_HUNT2:
            begin
                if (byte_in)
                begin
                    if (sts.second_hit)
                    begin
                        cmd.start_data = 1'b1;
                        state_next     = ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_DATA:
            begin
                if (byte_in)
                begin
                    if (!sts.count_zero)
                    begin
                        cmd.store_byte = 1'b1;
                    end
                    else if (!sts.sum_ok)
                    begin
                        cmd.emit_event   = 1'b1;
                        cmd.event_status = sxfr_pkg::STATUS_BAD_SUM;
                        state_next       = ST_HUNT1;
                    end
                    else if (frame_pending_reg)
                    begin
                        cmd.emit_event   = 1'b1;
                        cmd.event_status = sxfr_pkg::STATUS_DROPPED;
                        state_next       = ST_HUNT1;
                    end
                    else
                    begin
                        cmd.rep_start      = 1'b1;
                        frame_pending_next = 1'b1;
                        state_next         = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_data = 1'b1;
                    state_next    = sts.rep_last ? ST_HUNT1 : ST_READ;
                end
            end
            default:
            begin
                // hunting the first sync word
                state_next = ST_HUNT1;
                if (byte_in && sts.first_hit)
                begin
                    cmd.load_first = 1'b1;
                    state_next     = ST_HUNT2;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_HUNT1;
            frame_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            frame_pending_reg <= frame_pending_next;
        end
    end

    // no input word is taken while a frame is replayed
    a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READ) || (state_reg == ST_EMIT)) |-> !in_ready)
        else $error("input taken during replay");

    // a good frame marks pending and starts the replay
    a_good_frame_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rep_start |=> (frame_pending_reg && (state_reg == ST_READ)))
        else $error("replay start did not set pending");

    // replay words are loaded only into a free output slot
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_data |-> sts.slot_free)
        else $error("replay word loaded into busy output");

endmodule

@@ hdl/sxfr_datapath.sv @@
// datapath: sync config, checksum, payload memory, replay index and output register
module sxfr_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sxfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_wdata,
    input  logic [7:0]                          rx_byte,
    input  sxfr_pkg::sxfr_cmd_t                 cmd,
    output sxfr_pkg::sxfr_sts_t                 sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          data_byte,
    output logic [sxfr_pkg::IDX_W-1:0]          byte_index,
    output logic [1:0]                          status,
    output logic                                last
);

    logic [7:0]                        first_sync_reg;
    logic [7:0]                        second_sync_reg;
    logic [7:0]                        running_xor_reg;
    logic [sxfr_pkg::IDX_W-1:0]        bytes_left_reg;
    logic [sxfr_pkg::ADDR_W-1:0]       wr_addr_reg;
    logic [sxfr_pkg::ADDR_W-1:0]       rep_idx_reg;
    logic [7:0]                        rd_data_reg;
    logic [7:0]                        store_mem [sxfr_pkg::PAYLOAD_BYTES];
    logic                              out_valid_reg;
    logic [7:0]                        data_byte_reg;
    logic [sxfr_pkg::IDX_W-1:0]        byte_index_reg;
    logic [1:0]                        status_reg;
    logic                              last_reg;

    // status toward the controller
    assign sts.first_hit  = (rx_byte == first_sync_reg);
    assign sts.second_hit = (rx_byte == second_sync_reg);
    assign sts.count_zero = (bytes_left_reg == '0);
    assign sts.sum_ok     = (rx_byte == running_xor_reg);
    assign sts.slot_free  = !out_valid_reg || out_ready;
    assign sts.rep_last   = (rep_idx_reg == sxfr_pkg::ADDR_W'(sxfr_pkg::PAYLOAD_BYTES - 1));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= sxfr_pkg::FIRST_SYNC_RST;
            second_sync_reg <= sxfr_pkg::SECOND_SYNC_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sxfr_pkg::CFG_FIRST_SYNC:  first_sync_reg  <= cfg_wdata;
                sxfr_pkg::CFG_SECOND_SYNC: second_sync_reg <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // checksum, byte count and memory pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_xor_reg <= '0;
            bytes_left_reg  <= '0;
            wr_addr_reg     <= '0;
            rep_idx_reg     <= '0;
        end
        else
        begin
            if (cmd.load_first)
            begin
                running_xor_reg <= rx_byte;
            end
            if (cmd.start_data)
            begin
                running_xor_reg <= running_xor_reg ^ rx_byte;
                bytes_left_reg  <= sxfr_pkg::IDX_W'(sxfr_pkg::PAYLOAD_BYTES);
                wr_addr_reg     <= '0;
            end
            if (cmd.store_byte)
            begin
                running_xor_reg <= running_xor_reg ^ rx_byte;
                bytes_left_reg  <= bytes_left_reg - sxfr_pkg::IDX_W'(1);
                wr_addr_reg     <= wr_addr_reg + sxfr_pkg::ADDR_W'(1);
            end
            if (cmd.rep_start)
            begin
                rep_idx_reg <= '0;
            end
            else if (cmd.emit_data)
            begin
                rep_idx_reg <= rep_idx_reg + sxfr_pkg::ADDR_W'(1);
            end
        end
    end

    // payload memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_mem[wr_addr_reg] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rep_idx_reg];
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_data || cmd.emit_event)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_data)
        begin
            data_byte_reg  <= rd_data_reg;
            byte_index_reg <= sxfr_pkg::IDX_W'(rep_idx_reg);
            status_reg     <= sxfr_pkg::STATUS_OK;
            last_reg       <= sts.rep_last;
        end
        else if (cmd.emit_event)
        begin
            data_byte_reg  <= '0;
            byte_index_reg <= '0;
            status_reg     <= cmd.event_status;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // only one source loads the output register at a time
    a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_data && cmd.emit_event))
        else $error("two output loads at once");

    // payload is stored only while bytes remain
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_byte |-> (bytes_left_reg != '0))
        else $error("payload store past frame end");

    // a word is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_data || cmd.emit_event) |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

endmodule

@@ hdl/sync_xor_frame_receiver_unit.sv @@
// top level of the two-sync-word serial frame receiver with xor checksum
// Each input word (a received serial byte, or a consume event) is taken by valid/ready.
// A checksum word that yields a result waits until the output register is free. A good
// frame is replayed as PAYLOAD_BYTES output words, each a payload memory read followed
// by an output load that waits for a free output register; input is held off during
// the replay. A bad checksum or a frame dropped because an earlier one is still pending
// gives one output word. The sync word values are written through the config port; the
// user must do so only while the block is idle, which the block itself does not enforce.
module sync_xor_frame_receiver_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sxfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [7:0]                      rx_byte,
    input  logic                            line_error,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      data_byte,
    output logic [sxfr_pkg::IDX_W-1:0]      byte_index,
    output logic [1:0]                      status,
    output logic                            last
);

    sxfr_pkg::sxfr_cmd_t cmd;
    sxfr_pkg::sxfr_sts_t sts;

    // controller
    sxfr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .line_error (line_error),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    sxfr_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .status     (status),
        .last       (last)
    );

endmodule

@@ tb/sv/sync_xor_frame_receiver_unit_chk.sv @@
// checker for the frame receiver: tracks receiver state, predicts output words and compares
module sync_xor_frame_receiver_unit_chk
    import sxfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  func,
    input  logic [7:0]            rx_byte,
    input  logic                  line_error,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            data_byte,
    input  logic [IDX_W-1:0]      byte_index,
    input  logic [1:0]            status,
    input  logic                  last,
    output int                    mismatches,
    output int                    words_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_PAYLOAD} rx_phase_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic [1:0]       status;
        logic             last;
    } out_word_t;

    // mirror of the receiver state
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    rx_phase_t  rx_phase;
    logic [5:0] bytes_left;
    logic [7:0] frame_xor;
    logic [7:0] payload_copy [PAYLOAD_BYTES];
    logic       frame_held;

    out_word_t  due_words [$];

    initial
    begin
        mismatches    = 0;
        words_waiting = 0;
    end

    // queue one predicted output word
    task automatic push_word(input logic [7:0] d, input int idx, input logic [1:0] st,
                             input logic lst);
        out_word_t w;
        w.data_byte  = d;
        w.byte_index = IDX_W'(idx);
        w.status     = st;
        w.last       = lst;
        due_words.push_back(w);
    endtask

    // step the receiver mirror by one accepted input word
    task automatic advance_receiver(input logic f, input logic [7:0] b, input logic e);
        int i;
        if (f)
        begin
            // consume event frees the slot, even when nothing was held
            frame_held = 1'b0;
        end
        else if (!e)
        begin
            case (rx_phase)
                SEEK_SECOND:
                begin
                    if (b == second_sync)
                    begin
                        bytes_left = 6'(PAYLOAD_BYTES);
                        frame_xor  = frame_xor ^ b;
                        rx_phase   = IN_PAYLOAD;
                    end
                    else
                    begin
                        rx_phase = SEEK_FIRST;
                    end
                end
                IN_PAYLOAD:
                begin
                    if (bytes_left != 0)
                    begin
                        payload_copy[PAYLOAD_BYTES - int'(bytes_left)] = b;
                        frame_xor  = frame_xor ^ b;
                        bytes_left = bytes_left - 6'd1;
                    end
                    else
                    begin
                        // checksum word closes the frame
                        if (b != frame_xor)
                            push_word(8'h00, 0, STATUS_BAD_SUM, 1'b1);
                        else if (frame_held)
                            push_word(8'h00, 0, STATUS_DROPPED, 1'b1);
                        else
                        begin
                            for (i = 0; i < PAYLOAD_BYTES; i++)
                                push_word(payload_copy[i], i, STATUS_OK,
                                          i == PAYLOAD_BYTES - 1);
                            frame_held = 1'b1;
                        end
                        rx_phase = SEEK_FIRST;
                    end
                end
                default:
                begin
                    rx_phase = SEEK_FIRST;
                    if (b == first_sync)
                    begin
                        frame_xor = b;
                        rx_phase  = SEEK_SECOND;
                    end
                end
            endcase
        end
    endtask

    // compare one field and count a mismatch
    task automatic match_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // watch config, input and output channels
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t w;
        if (!rst_n)
        begin
            first_sync  = FIRST_SYNC_RST;
            second_sync = SECOND_SYNC_RST;
            rx_phase    = SEEK_FIRST;
            bytes_left  = '0;
            frame_xor   = '0;
            frame_held  = 1'b0;
            due_words.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FIRST_SYNC:  first_sync  = cfg_wdata;
                    CFG_SECOND_SYNC: second_sync = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                advance_receiver(func, rx_byte, line_error);
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected output word: data_byte 0x%0h byte_index %0d status %0d",
                           data_byte, byte_index, status);
                    mismatches++;
                end
                else
                begin
                    w = due_words.pop_front();
                    match_field("data_byte", w.data_byte, data_byte);
                    match_field("byte_index", 8'(w.byte_index), 8'(byte_index));
                    match_field("status", 8'(w.status), 8'(status));
                    match_field("last", 8'(w.last), 8'(last));
                end
            end
        end
        words_waiting = due_words.size();
    end

endmodule

@@ tb/sv/sync_xor_frame_receiver_unit_tb.sv @@
// top of the frame receiver testbench: clock, reset, stimulus and verdict
module sync_xor_frame_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sxfr_pkg::*;

    localparam int ITEMS_PER_PHASE = 20;
    localparam int NUM_PHASES      = 5;
    localparam int SETTLE_CYCLES   = 2 * PAYLOAD_BYTES + 24;
    localparam int CYCLE_LIMIT     = 300000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [7:0]           cfg_wdata  = '0;
    logic                 in_valid   = 1'b0;
    logic                 func       = 1'b0;
    logic [7:0]           rx_byte    = '0;
    logic                 line_error = 1'b0;
    logic                 out_ready  = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [7:0]           data_byte;
    logic [IDX_W-1:0]     byte_index;
    logic [1:0]           status;
    logic                 last;

    int         mismatches;
    int         words_waiting;
    int         items_sent  = 0;
    int         cycle_count = 0;
    int         stall_left  = 0;
    logic       calm        = 1'b0;
    logic [7:0] first_sync  = FIRST_SYNC_RST;
    logic [7:0] second_sync = SECOND_SYNC_RST;

    sync_xor_frame_receiver_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .rx_byte    (rx_byte),
        .line_error (line_error),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .status     (status),
        .last       (last)
    );

    sync_xor_frame_receiver_unit_chk frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .rx_byte       (rx_byte),
        .line_error    (line_error),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .status        (status),
        .last          (last),
        .mismatches    (mismatches),
        .words_waiting (words_waiting)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sync_xor_frame_receiver_unit");
            $finish;
        end
    end

    // output side stalls in random bursts unless calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // offer one input word and hold it until taken
    task automatic send_word(input logic f, input logic [7:0] b, input logic e);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        rx_byte    <= b;
        line_error <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (f || !e)
            items_sent++;
    endtask

    // byte values weighted toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // flagged bytes and consume events scattered through a frame
    task automatic maybe_interleave();
        if ($urandom_range(0, 9) == 0)
            send_word(1'b0, $urandom_range(0, 1) ? first_sync : pick_byte(), 1'b1);
        if ($urandom_range(0, 15) == 0)
            send_word(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // full frame: both sync words, payload, checksum word
    task automatic send_frame(input logic good_sum, input logic walking);
        int         i;
        logic [7:0] b;
        logic [7:0] sum;
        sum = first_sync ^ second_sync;
        send_word(1'b0, first_sync, 1'b0);
        maybe_interleave();
        send_word(1'b0, second_sync, 1'b0);
        for (i = 0; i < PAYLOAD_BYTES; i++)
        begin
            maybe_interleave();
            if (walking)
                b = (i < 2) ? {8{i[0]}} : 8'(8'h01 << (i % 8));
            else
                b = pick_byte();
            sum = sum ^ b;
            send_word(1'b0, b, 1'b0);
        end
        maybe_interleave();
        send_word(1'b0, good_sum ? sum : sum ^ 8'($urandom_range(1, 255)), 1'b0);
    endtask

    // one random piece of traffic, mostly well-formed frames
    task automatic random_traffic();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_frame($urandom_range(0, 6) != 0, 1'b0);
        else if (pick < 85)
        begin
            // broken start: first sync then a wrong or repeated word
            send_word(1'b0, first_sync, 1'b0);
            send_word(1'b0, $urandom_range(0, 1) ? first_sync : pick_byte(), 1'b0);
        end
        else if (pick < 93)
            send_word(1'b1, 8'($urandom), 1'($urandom));
        else
            send_word(1'b0, pick_byte(), 1'($urandom));
    endtask

    // register write through the config port
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == CFG_FIRST_SYNC)
            first_sync = val;
        else
            second_sync = val;
    endtask

    // stop input and let all expected words come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        int         p;
        int         goal;
        logic [7:0] sync_a;
        logic [7:0] sync_b;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: consume with nothing held, flagged sync word, repeated first sync,
        // stray second sync, then a frame with extreme and walking-one payload
        send_word(1'b1, 8'hFF, 1'b1);
        send_word(1'b0, first_sync, 1'b1);
        send_word(1'b0, first_sync, 1'b0);
        send_word(1'b0, first_sync, 1'b0);
        send_word(1'b0, second_sync, 1'b0);
        send_frame(1'b1, 1'b1);
        drain();

        // random phases under different sync settings
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                case (p)
                    1:       begin sync_a = 8'h00; sync_b = 8'hFF; end
                    2:       begin sync_a = 8'hFF; sync_b = 8'h00; end
                    3:       begin sync_a = 8'h5A; sync_b = 8'h5A; end
                    default: begin sync_a = 8'($urandom); sync_b = 8'($urandom); end
                endcase
                write_reg(CFG_FIRST_SYNC, sync_a);
                write_reg(CFG_SECOND_SYNC, sync_b);
            end
            // last phase runs with no idling on either side
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
                random_traffic();
        end
        drain();

        if (words_waiting != 0)
            $error("%0d expected output words never arrived", words_waiting);
        if (mismatches == 0 && words_waiting == 0)
            $display("PASS sync_xor_frame_receiver_unit");
        else
            $display("FAIL sync_xor_frame_receiver_unit");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sxfr_pkg.sv
hdl/sxfr_ctrl.sv
hdl/sxfr_datapath.sv
hdl/sync_xor_frame_receiver_unit.sv
tb/sv/sync_xor_frame_receiver_unit_chk.sv
tb/sv/sync_xor_frame_receiver_unit_tb.sv
